@@ rtl/core/sspq_pkg.sv @@
package sspq_pkg;

  // field widths of one request and one result word
  localparam int unsigned ValueW = 16;
  localparam int unsigned TagW = 8;
  localparam int unsigned CountW = 5;

  // default number of cells
  localparam int unsigned CapacityDefault = 16;

  // request codes
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_POP    = 1'b1
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // one stored entry
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [TagW-1:0]   tag;
  } entry_t;

  // broadcast from the top level to every cell
  typedef struct packed {
    logic              ins_en;
    logic              pop_en;
    logic [ValueW-1:0] value;
    logic [TagW-1:0]   tag;
  } cell_ctrl_t;

endpackage

@@ rtl/core/sspq_if.sv @@
interface sspq_req_if;
  import sspq_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ValueW-1:0] new_value;
  logic [TagW-1:0]   new_tag;

  modport source (output valid, output req_type, output new_value, output new_tag,
                  input ready);
  modport sink (input valid, input req_type, input new_value, input new_tag,
                output ready);
endinterface

interface sspq_res_if;
  import sspq_pkg::*;

  logic              valid;
  logic              ready;
  logic              popped_valid;
  logic [ValueW-1:0] popped_value;
  logic [TagW-1:0]   popped_tag;
  logic [CountW-1:0] entry_count;
  logic [1:0]        status;

  modport source (output valid, output popped_valid, output popped_value,
                  output popped_tag, output entry_count, output status,
                  input ready);
  modport sink (input valid, input popped_valid, input popped_value,
                input popped_tag, input entry_count, input status,
                output ready);
endinterface

@@ rtl/core/sspq_cell.sv @@
module sspq_cell (
  input  logic                clk_i,
  input  sspq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occ_i,
  input  logic                take_left_i,
  input  sspq_pkg::entry_t    left_i,
  input  sspq_pkg::entry_t    right_i,
  output logic                take_o,
  output sspq_pkg::entry_t    entry_o
);
  import sspq_pkg::*;

  entry_t entry_q, entry_d;

  // new word lands in the first cell that is empty or holds a smaller value
  assign take_o = !occ_i || (ctrl_i.value > entry_q.value);

  // shift right on insert below the landing cell, shift left on pop
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.pop_en) begin
      entry_d = right_i;
    end else if (ctrl_i.ins_en) begin
      if (take_left_i) begin
        entry_d = left_i;
      end else if (take_o) begin
        entry_d.value = ctrl_i.value;
        entry_d.tag   = ctrl_i.tag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

@@ rtl/core/stable_sorted_priority_queue.sv @@
// Sorted priority queue, highest value at the head, equal values in arrival order.
// req_i carries one request word: req_type selects insert (new_value, new_tag)
// or pop of the head entry. res_o returns exactly one result word per request:
// popped entry (on a successful pop), entry count after the request, status.
// The entries sit in a row of CAPACITY cells; every cell compares the incoming
// value against its own entry in parallel and shifts towards its neighbour, so
// a request is applied in the cycle it is accepted.
// Latency: the result word is valid in the cycle after acceptance.
// Throughput: one request per cycle while res_o is taken; the output register
// is the only buffer, so req_i.ready is low only when a result waits and
// res_o.ready is low.
// An insert into a full queue is dropped with status full; a pop on an empty
// queue returns status empty and a zero entry.
// Reset empties the queue and the output register at once; no clearing pass.
module stable_sorted_priority_queue #(
  parameter int unsigned CAPACITY = sspq_pkg::CapacityDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sspq_req_if.sink   req_i,
  sspq_res_if.source res_o
);
  import sspq_pkg::*;

  localparam int unsigned CntW = $clog2(CAPACITY + 1);

  logic [CntW-1:0] count_q, count_d;
  logic            accept;
  logic            is_pop, empty, full;
  cell_ctrl_t      ctrl;
  logic            take [CAPACITY];
  entry_t          cell_entry [CAPACITY];

  logic              res_valid_q;
  logic              pvalid_q, pvalid_d;
  logic [ValueW-1:0] pvalue_q, pvalue_d;
  logic [TagW-1:0]   ptag_q, ptag_d;
  logic [CountW-1:0] ecount_q, ecount_d;
  status_e           status_q, status_d;

  assign req_i.ready = !res_valid_q || res_o.ready;
  assign accept      = req_i.valid && req_i.ready;
  assign is_pop      = (req_i.req_type == REQ_POP);
  assign empty       = (count_q == '0);
  assign full        = (count_q == CntW'(CAPACITY));

  // broadcast to the cells
  always_comb begin
    ctrl.ins_en = accept && !is_pop && !full;
    ctrl.pop_en = accept && is_pop && !empty;
    ctrl.value  = req_i.new_value;
    ctrl.tag    = req_i.new_tag;
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic   occ;
    logic   take_left;
    entry_t left, right;

    assign occ = (count_q > CntW'(i));
    if (i == 0) begin : g_first
      assign take_left = 1'b0;
      assign left      = '0;
    end else begin : g_mid
      assign take_left = take[i-1];
      assign left      = cell_entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = cell_entry[i+1];
    end

    sspq_cell u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl),
      .occ_i      (occ),
      .take_left_i(take_left),
      .left_i     (left),
      .right_i    (right),
      .take_o     (take[i]),
      .entry_o    (cell_entry[i])
    );
  end

  // entry count and result word
  always_comb begin
    count_d  = count_q;
    pvalid_d = 1'b0;
    pvalue_d = '0;
    ptag_d   = '0;
    status_d = ST_OK;
    if (ctrl.ins_en) begin
      count_d = count_q + 1'b1;
    end else if (ctrl.pop_en) begin
      count_d  = count_q - 1'b1;
      pvalid_d = 1'b1;
      pvalue_d = cell_entry[0].value;
      ptag_d   = cell_entry[0].tag;
    end else if (is_pop) begin
      status_d = ST_EMPTY;
    end else begin
      status_d = ST_FULL;
    end
    ecount_d = CountW'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q <= count_d;
      end
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pvalid_q <= pvalid_d;
      pvalue_q <= pvalue_d;
      ptag_q   <= ptag_d;
      ecount_q <= ecount_d;
      status_q <= status_d;
    end
  end

  assign res_o.valid        = res_valid_q;
  assign res_o.popped_valid = pvalid_q;
  assign res_o.popped_value = pvalue_q;
  assign res_o.popped_tag   = ptag_q;
  assign res_o.entry_count  = ecount_q;
  assign res_o.status       = status_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q >= CntW'(2)) |-> (cell_entry[0].value >= cell_entry[1].value))
    else $error("head cell out of order");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.pop_en |=> (count_q == $past(count_q) - 1'b1))
    else $error("pop did not decrement count");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_pop && full) |=> ($stable(count_q) && status_q == ST_FULL))
    else $error("insert into full queue not dropped");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import sspq_pkg::*;

  localparam int Cap = CapacityDefault;

  // one result word as the queue should report it
  typedef struct packed {
    logic              popped_valid;
    logic [ValueW-1:0] popped_value;
    logic [TagW-1:0]   popped_tag;
    logic [CountW-1:0] entry_count;
    status_e           status;
  } queue_result_t;

  logic clk_i;
  logic rst_ni;

  sspq_req_if req_if ();
  sspq_res_if res_if ();

  stable_sorted_priority_queue #(
    .CAPACITY(Cap)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .res_o (res_if)
  );

  // shadow copy of the sorted slots, head in slot 0
  entry_t        shadow_slots [Cap];
  int            shadow_count;
  queue_result_t pending_results [$];
  bit            failed;
  bit            steady;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // watchdog
  initial begin
    #1000000;
    $display("Verification failed");
    $finish;
  end

  // gap length, mostly short, now and then long
  function automatic int unsigned idle_len();
    int unsigned r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // priority values with extremes and plenty of ties
  function automatic logic [ValueW-1:0] rand_value(input bit narrow);
    int unsigned r;
    if (narrow) return ValueW'($urandom_range(0, 3));
    r = $urandom_range(0, 9);
    case (r)
      0: return '0;
      1: return '1;
      2, 3: return ValueW'($urandom_range(0, 3));
      default: return ValueW'($urandom);
    endcase
  endfunction

  // apply one accepted request word to the shadow queue and queue its result
  task automatic predict_result(input req_e kind, input logic [ValueW-1:0] value,
                                input logic [TagW-1:0] tag);
    queue_result_t res;
    int            pos;
    res = '0;
    res.status = ST_OK;
    if (kind == REQ_INSERT) begin
      if (shadow_count >= Cap) begin
        res.status = ST_FULL;
      end else begin
        // new entry goes behind every entry of equal or higher value
        pos = 0;
        while (pos < shadow_count && shadow_slots[pos].value >= value) pos++;
        for (int i = shadow_count; i > pos; i--) shadow_slots[i] = shadow_slots[i-1];
        shadow_slots[pos].value = value;
        shadow_slots[pos].tag = tag;
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.popped_valid = 1'b1;
      res.popped_value = shadow_slots[0].value;
      res.popped_tag = shadow_slots[0].tag;
      for (int i = 1; i < shadow_count; i++) shadow_slots[i-1] = shadow_slots[i];
      shadow_count--;
    end
    res.entry_count = CountW'(shadow_count);
    pending_results.push_back(res);
  endtask

  // drive one request word and wait for it to be taken
  task automatic send_word(input req_e kind, input logic [ValueW-1:0] value,
                           input logic [TagW-1:0] tag);
    int unsigned gap;
    gap = idle_len();
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.req_type <= kind;
    req_if.new_value <= value;
    req_if.new_tag <= tag;
    do @(posedge clk_i); while (!req_if.ready);
    predict_result(kind, value, tag);
  endtask

  task automatic send_random(input int insert_pct, input bit narrow);
    req_e kind;
    kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_POP;
    send_word(kind, rand_value(narrow), TagW'($urandom));
  endtask

  // result side: random back-pressure
  initial begin
    int unsigned stall;
    res_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_len();
      if (stall != 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
  end

  // compare each result word with the oldest expectation
  always @(posedge clk_i) begin : check_results
    queue_result_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        $error("result word with no request outstanding");
        failed = 1'b1;
      end else begin
        want = pending_results.pop_front();
        if (res_if.popped_valid !== want.popped_valid) begin
          $error("popped_valid: expected %0d, got %0d", want.popped_valid,
                 res_if.popped_valid);
          failed = 1'b1;
        end
        if (res_if.popped_value !== want.popped_value) begin
          $error("popped_value: expected %0d, got %0d", want.popped_value,
                 res_if.popped_value);
          failed = 1'b1;
        end
        if (res_if.popped_tag !== want.popped_tag) begin
          $error("popped_tag: expected %0d, got %0d", want.popped_tag, res_if.popped_tag);
          failed = 1'b1;
        end
        if (res_if.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", want.entry_count,
                 res_if.entry_count);
          failed = 1'b1;
        end
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.status);
          failed = 1'b1;
        end
      end
    end
  end

  // pop straight after reset returns the empty status
  task automatic test_empty_pop();
    send_word(REQ_POP, '0, '0);
    send_word(REQ_POP, '1, '1);
  endtask

  // extreme values and tags, ties at both ends of the range
  task automatic test_extremes();
    send_word(REQ_INSERT, 16'd100, 8'd1);
    send_word(REQ_INSERT, 16'd100, 8'd2);
    send_word(REQ_INSERT, '1, '1);
    send_word(REQ_INSERT, '0, '0);
    send_word(REQ_INSERT, '1, '0);
    send_word(REQ_INSERT, '0, '1);
    repeat (6) send_word(REQ_POP, 16'h5a5a, 8'ha5);
    send_word(REQ_POP, '0, '0);
  endtask

  // fill to capacity, push past it, then drain past empty
  task automatic test_fill_and_overflow();
    for (int round = 0; round < 8; round++) begin
      while (shadow_count < Cap) send_word(REQ_INSERT, rand_value(round[0]), TagW'($urandom));
      repeat ($urandom_range(1, 3)) send_word(REQ_INSERT, rand_value(1'b0), TagW'($urandom));
      // churn around the full mark
      repeat ($urandom_range(0, 6)) send_random(50, round[0]);
      while (shadow_count > 0) send_word(REQ_POP, rand_value(1'b0), TagW'($urandom));
      repeat ($urandom_range(1, 2)) send_word(REQ_POP, rand_value(1'b0), TagW'($urandom));
    end
  endtask

  // mixed traffic, insert share drifting per block
  task automatic test_random_mix();
    int insert_pct;
    for (int blk = 0; blk < 14; blk++) begin
      insert_pct = $urandom_range(25, 75);
      repeat (50) send_random(insert_pct, 1'b0);
    end
  endtask

  // one word per cycle on both sides
  task automatic test_back_to_back();
    steady = 1'b1;
    repeat (300) send_random(55, 1'($urandom_range(0, 1)));
    steady = 1'b0;
  endtask

  // very few distinct values so arrival order decides the pop order
  task automatic test_tie_order();
    repeat (150) send_random(55, 1'b1);
  endtask

  initial begin
    int guard;
    failed = 1'b0;
    steady = 1'b0;
    shadow_count = 0;
    rst_ni <= 1'b0;
    req_if.valid <= 1'b0;
    req_if.req_type <= REQ_INSERT;
    req_if.new_value <= '0;
    req_if.new_tag <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_pop();
    test_extremes();
    test_fill_and_overflow();
    test_random_mix();
    test_back_to_back();
    test_tie_order();
    req_if.valid <= 1'b0;

    // drain outstanding results, then a few spare cycles
    guard = 0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d result words never arrived", pending_results.size());
      failed = 1'b1;
    end

    if (!failed) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
